// File: sv/pn_pkg.sv
// ----------------------------------------------------------------------------
// pn_pkg: shared types, constants and parser function of the path normaliser
// Parser state codes, sequencer states, transfer payload structs and the
// one-byte component parser used by the sequencer.
// ----------------------------------------------------------------------------
package pn_pkg;

  localparam int LINE_DEPTH_DEF = 256;
  localparam int LEN_W          = 9;
  localparam int LEN_MAX        = 511;
  localparam int CFG_IDX_W      = 1;

  localparam logic [7:0] SEP_DEFAULT      = 8'd47;
  localparam logic [7:0] DOT_DEFAULT      = 8'd46;
  localparam logic [7:0] JOIN_SEP_DEFAULT = 8'd47;
  localparam logic [7:0] NUL_CHAR         = 8'd0;

  localparam logic [CFG_IDX_W-1:0] CFG_SEPARATOR = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DOT       = 1'b1;

  localparam logic REQ_PUSH = 1'b0;
  localparam logic REQ_READ = 1'b1;

  typedef enum logic [2:0] {
    PS_INIT,
    PS_SEP,
    PS_FIELD,
    PS_DOT,
    PS_DOTDOT
  } parse_state_t;

  typedef enum logic [3:0] {
    SQ_IDLE,
    SQ_STEP,
    SQ_PUT,
    SQ_BU,
    SQ_BU_ROOT,
    SQ_BU_SCAN,
    SQ_BU_CHECK,
    SQ_FIN,
    SQ_FIN_CHECK,
    SQ_RD_CHECK,
    SQ_DONE
  } seq_state_t;

  typedef struct packed {
    logic       req_type;
    logic [7:0] path_byte;
    logic       from_request;
    logic [7:0] read_index;
  } pn_item_t;

  typedef struct packed {
    logic [LEN_W-1:0] result_length;
    logic             overflowed;
    logic [7:0]       read_byte;
  } pn_result_t;

  typedef struct packed {
    parse_state_t next_state;
    logic         put_en;
    logic [1:0]   put_dots;
    logic         back_up;
  } pn_parse_t;

  // one byte through the component parser; b is never nul
  function automatic pn_parse_t pn_parse(parse_state_t st, logic [7:0] b,
                                         logic [7:0] sep, logic [7:0] dot);
    pn_parse_t r;
    logic      is_sep;
    logic      is_dot;
    is_sep       = (b == sep);
    is_dot       = (b == dot);
    r.next_state = st;
    r.put_en     = 1'b0;
    r.put_dots   = 2'd0;
    r.back_up    = 1'b0;
    case (st)
      PS_SEP: begin
        if (is_sep) begin
          r.next_state = PS_SEP;
        end else if (is_dot) begin
          r.next_state = PS_DOT;
        end else begin
          r.put_en     = 1'b1;
          r.next_state = PS_FIELD;
        end
      end
      PS_FIELD: begin
        r.put_en = 1'b1;
        if (is_sep) begin
          r.next_state = PS_SEP;
        end
      end
      PS_DOT: begin
        if (is_dot) begin
          r.next_state = PS_DOTDOT;
        end else if (is_sep) begin
          r.next_state = PS_SEP;
        end else begin
          r.put_en     = 1'b1;
          r.put_dots   = 2'd1;
          r.next_state = PS_FIELD;
        end
      end
      PS_DOTDOT: begin
        if (is_sep) begin
          r.back_up    = 1'b1;
          r.next_state = PS_SEP;
        end else begin
          r.put_en     = 1'b1;
          r.put_dots   = 2'd2;
          r.next_state = PS_FIELD;
        end
      end
      default: begin
        if (is_sep) begin
          r.put_en     = 1'b1;
          r.next_state = PS_SEP;
        end else if (is_dot) begin
          r.next_state = PS_DOT;
        end else begin
          r.put_en     = 1'b1;
          r.next_state = PS_FIELD;
        end
      end
    endcase
    return r;
  endfunction

endpackage

// File: sv/path_normalizer_unit.sv
// ----------------------------------------------------------------------------
// path_normalizer_unit: streaming path normaliser with line store
// Builds a normalised absolute path from directory and request bytes and
// serves read-back of the stored path.
//
//   channel  direction  handshake          payload
//   in_      input      in_valid/in_ready  req_type, path_byte, from_request,
//                                          read_index
//   out_     output     out_valid/out_ready result_length, overflowed, read_byte
//   cfg_     input      cfg_we             cfg_index, cfg_data
//
// A path byte is accepted, parsed and dispatched, with one store write per
// stored byte; a joining separator adds one parse step. A nul finishes the
// path after any join and trailing parent walk. A parent component walks
// back byte by byte through the registered store read port. in_ready is low
// while a transfer is worked on or its result waits for the output register;
// reset is synchronous, the store not cleared.
// ----------------------------------------------------------------------------
module path_normalizer_unit #(
  parameter int LINE_DEPTH = pn_pkg::LINE_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_req_type,
  input  logic [7:0]                   in_path_byte,
  input  logic                         in_from_request,
  input  logic [7:0]                   in_read_index,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [pn_pkg::LEN_W-1:0]     out_result_length,
  output logic                         out_overflowed,
  output logic [7:0]                   out_read_byte,
  input  logic                         cfg_we,
  input  logic [pn_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                   cfg_data
);

  localparam int AW = $clog2(LINE_DEPTH);

  logic [7:0]         sep_r, sep_nxt;
  logic [7:0]         dot_r, dot_nxt;
  logic               out_valid_r, out_valid_nxt;
  pn_pkg::pn_result_t out_r;
  pn_pkg::pn_item_t   item;
  pn_pkg::pn_result_t res;
  logic               res_valid;
  logic               res_ready;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [7:0]         mem_wdata;
  logic [AW-1:0]      mem_raddr;
  logic [7:0]         mem_rdata;

  assign item.req_type     = in_req_type;
  assign item.path_byte    = in_path_byte;
  assign item.from_request = in_from_request;
  assign item.read_index   = in_read_index;

  always_comb begin
    sep_nxt = sep_r;
    dot_nxt = dot_r;
    if (cfg_we) begin
      case (cfg_index)
        pn_pkg::CFG_SEPARATOR: sep_nxt = cfg_data;
        pn_pkg::CFG_DOT:       dot_nxt = cfg_data;
        default: begin
        end
      endcase
    end
  end

  // output register frees the sequencer once the result is taken
  assign res_ready     = !out_valid_r || out_ready;
  assign out_valid_nxt = res_valid || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sep_r       <= pn_pkg::SEP_DEFAULT;
      dot_r       <= pn_pkg::DOT_DEFAULT;
      out_valid_r <= 1'b0;
    end else begin
      sep_r       <= sep_nxt;
      dot_r       <= dot_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_result_length = out_r.result_length;
  assign out_overflowed    = out_r.overflowed;
  assign out_read_byte     = out_r.read_byte;

  pn_seq #(
    .LINE_DEPTH(LINE_DEPTH)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .sep_char  (sep_r),
    .dot_char  (dot_r),
    .item_valid(in_valid),
    .item_ready(in_ready),
    .item      (item),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  pn_store #(
    .LINE_DEPTH(LINE_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

endmodule

// File: sv/pn_store.sv
// ----------------------------------------------------------------------------
// pn_store: line store of the path normaliser
// Single-port-write, single-port-read memory with registered read data.
// ----------------------------------------------------------------------------
module pn_store #(
  parameter int LINE_DEPTH = pn_pkg::LINE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          we,
  input  logic [$clog2(LINE_DEPTH)-1:0] waddr,
  input  logic [7:0]                    wdata,
  input  logic [$clog2(LINE_DEPTH)-1:0] raddr,
  output logic [7:0]                    rdata
);

  logic [7:0] mem [LINE_DEPTH];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: sv/pn_seq.sv
// ----------------------------------------------------------------------------
// pn_seq: parse sequencer of the path normaliser
// Runs each push transfer through parse, store-write, back-up and finish
// steps, and each read transfer through a store lookup.
// ----------------------------------------------------------------------------
module pn_seq #(
  parameter int LINE_DEPTH = pn_pkg::LINE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [7:0]                    sep_char,
  input  logic [7:0]                    dot_char,
  input  logic                          item_valid,
  output logic                          item_ready,
  input  pn_pkg::pn_item_t              item,
  output logic                          res_valid,
  input  logic                          res_ready,
  output pn_pkg::pn_result_t            res,
  output logic                          mem_we,
  output logic [$clog2(LINE_DEPTH)-1:0] mem_waddr,
  output logic [7:0]                    mem_wdata,
  output logic [$clog2(LINE_DEPTH)-1:0] mem_raddr,
  input  logic [7:0]                    mem_rdata
);

  localparam int AW = $clog2(LINE_DEPTH);
  localparam int PW = $clog2(LINE_DEPTH + 1);
  localparam int CW = (PW > pn_pkg::LEN_W) ? PW : pn_pkg::LEN_W;

  localparam logic [PW-1:0] WP_FULL = PW'(LINE_DEPTH);
  localparam logic [PW-1:0] WP_ONE  = PW'(1);

  pn_pkg::seq_state_t   state_r, state_nxt;
  pn_pkg::parse_state_t pstate_r, pstate_nxt;
  logic [PW-1:0]        wp_r, wp_nxt;
  logic [PW-1:0]        flen_r, flen_nxt;
  logic                 req_r, req_nxt;
  logic                 ovf_r, ovf_nxt;
  logic                 todo_join_r, todo_join_nxt;
  logic                 todo_char_r, todo_char_nxt;
  logic                 todo_fin_r, todo_fin_nxt;
  logic                 todo_end_r, todo_end_nxt;
  logic [7:0]           c_r, c_nxt;
  logic [7:0]           ridx_r, ridx_nxt;
  logic [1:0]           put_dots_r, put_dots_nxt;
  logic [7:0]           put_last_r, put_last_nxt;
  logic [7:0]           res_byte_r, res_byte_nxt;

  logic                 accept;
  logic                 c_nul;
  logic                 start_req;
  logic                 discard;
  logic [7:0]           join_sep;
  logic [7:0]           parse_in;
  pn_pkg::pn_parse_t    pr;
  logic [PW-1:0]        wp_m1;
  logic                 read_in_range;

  assign item_ready = (state_r == pn_pkg::SQ_IDLE);
  assign accept     = item_valid && item_ready;
  assign c_nul      = (item.path_byte == pn_pkg::NUL_CHAR);
  assign start_req  = !req_r && (item.from_request || c_nul);
  assign discard    = start_req && !c_nul && (item.path_byte == sep_char);
  assign join_sep   = (sep_char != pn_pkg::NUL_CHAR) ? sep_char : pn_pkg::JOIN_SEP_DEFAULT;
  assign parse_in   = todo_join_r ? join_sep : c_r;
  assign pr         = pn_pkg::pn_parse(pstate_r, parse_in, sep_char, dot_char);
  assign wp_m1      = wp_r - WP_ONE;
  // final length never exceeds the depth, so this also bounds the address
  assign read_in_range = (CW'(ridx_r) < CW'(flen_r));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pn_pkg::SQ_IDLE: begin
        if (accept) begin
          if (item.req_type == pn_pkg::REQ_READ) begin
            state_nxt = pn_pkg::SQ_RD_CHECK;
          end else begin
            state_nxt = pn_pkg::SQ_STEP;
          end
        end
      end
      pn_pkg::SQ_STEP: begin
        if (todo_join_r || todo_char_r) begin
          if (pr.put_en) begin
            state_nxt = pn_pkg::SQ_PUT;
          end else if (pr.back_up) begin
            state_nxt = pn_pkg::SQ_BU;
          end else begin
            state_nxt = pn_pkg::SQ_STEP;
          end
        end else if (todo_fin_r) begin
          if (pstate_r == pn_pkg::PS_DOTDOT) begin
            state_nxt = pn_pkg::SQ_BU;
          end else begin
            state_nxt = pn_pkg::SQ_FIN;
          end
        end else if (todo_end_r) begin
          state_nxt = pn_pkg::SQ_DONE;
        end else begin
          state_nxt = pn_pkg::SQ_IDLE;
        end
      end
      pn_pkg::SQ_PUT: begin
        if (put_dots_r == 2'd0) begin
          state_nxt = pn_pkg::SQ_STEP;
        end
      end
      pn_pkg::SQ_BU: begin
        if (wp_r == '0) begin
          state_nxt = pn_pkg::SQ_STEP;
        end else if (wp_r == WP_ONE) begin
          state_nxt = pn_pkg::SQ_BU_ROOT;
        end else begin
          state_nxt = pn_pkg::SQ_BU_SCAN;
        end
      end
      pn_pkg::SQ_BU_ROOT: state_nxt = pn_pkg::SQ_STEP;
      pn_pkg::SQ_BU_SCAN: begin
        if (wp_r == '0) begin
          state_nxt = pn_pkg::SQ_STEP;
        end else begin
          state_nxt = pn_pkg::SQ_BU_CHECK;
        end
      end
      pn_pkg::SQ_BU_CHECK: begin
        if (mem_rdata != sep_char) begin
          state_nxt = pn_pkg::SQ_BU_SCAN;
        end else begin
          state_nxt = pn_pkg::SQ_STEP;
        end
      end
      pn_pkg::SQ_FIN: begin
        if (wp_r == '0) begin
          state_nxt = pn_pkg::SQ_PUT;
        end else if (wp_r > WP_ONE) begin
          state_nxt = pn_pkg::SQ_FIN_CHECK;
        end else begin
          state_nxt = pn_pkg::SQ_STEP;
        end
      end
      pn_pkg::SQ_FIN_CHECK: state_nxt = pn_pkg::SQ_STEP;
      pn_pkg::SQ_RD_CHECK:  state_nxt = pn_pkg::SQ_DONE;
      pn_pkg::SQ_DONE: begin
        if (res_ready) begin
          state_nxt = pn_pkg::SQ_IDLE;
        end
      end
      default: state_nxt = pn_pkg::SQ_IDLE;
    endcase
  end

  // datapath and store access
  always_comb begin
    pstate_nxt    = pstate_r;
    wp_nxt        = wp_r;
    flen_nxt      = flen_r;
    req_nxt       = req_r;
    ovf_nxt       = ovf_r;
    todo_join_nxt = todo_join_r;
    todo_char_nxt = todo_char_r;
    todo_fin_nxt  = todo_fin_r;
    todo_end_nxt  = todo_end_r;
    c_nxt         = c_r;
    ridx_nxt      = ridx_r;
    put_dots_nxt  = put_dots_r;
    put_last_nxt  = put_last_r;
    res_byte_nxt  = res_byte_r;
    mem_we        = 1'b0;
    mem_waddr     = wp_r[AW-1:0];
    mem_wdata     = put_last_r;
    mem_raddr     = wp_m1[AW-1:0];
    case (state_r)
      pn_pkg::SQ_IDLE: begin
        mem_raddr = AW'(item.read_index);
        if (accept) begin
          ridx_nxt = item.read_index;
          if (item.req_type == pn_pkg::REQ_PUSH) begin
            c_nxt         = item.path_byte;
            todo_join_nxt = start_req && !discard;
            todo_char_nxt = !c_nul;
            todo_fin_nxt  = c_nul;
            todo_end_nxt  = c_nul;
            if (pstate_r == pn_pkg::PS_INIT && !req_r && wp_r == '0) begin
              ovf_nxt = 1'b0;
            end
            if (start_req) begin
              req_nxt = 1'b1;
            end
            if (discard) begin
              pstate_nxt = pn_pkg::PS_INIT;
              wp_nxt     = '0;
              ovf_nxt    = 1'b0;
            end
          end
        end
      end
      pn_pkg::SQ_STEP: begin
        if (todo_join_r || todo_char_r) begin
          pstate_nxt   = pr.next_state;
          put_dots_nxt = pr.put_dots;
          put_last_nxt = parse_in;
          if (todo_join_r) begin
            todo_join_nxt = 1'b0;
          end else begin
            todo_char_nxt = 1'b0;
          end
        end else if (todo_fin_r) begin
          // a trailing parent component backs up before the finish
          if (pstate_r == pn_pkg::PS_DOTDOT) begin
            pstate_nxt = pn_pkg::PS_INIT;
          end else begin
            todo_fin_nxt = 1'b0;
          end
        end else if (todo_end_r) begin
          todo_end_nxt = 1'b0;
          flen_nxt     = wp_r;
          wp_nxt       = '0;
          pstate_nxt   = pn_pkg::PS_INIT;
          req_nxt      = 1'b0;
          res_byte_nxt = pn_pkg::NUL_CHAR;
        end
      end
      pn_pkg::SQ_PUT: begin
        if (put_dots_r != 2'd0) begin
          mem_wdata    = dot_char;
          put_dots_nxt = put_dots_r - 2'd1;
        end
        if (wp_r != WP_FULL) begin
          mem_we = 1'b1;
          wp_nxt = wp_r + WP_ONE;
        end else begin
          ovf_nxt = 1'b1;
        end
      end
      pn_pkg::SQ_BU: begin
        mem_raddr = '0;
        if (wp_r > WP_ONE) begin
          wp_nxt = wp_m1;
        end
      end
      pn_pkg::SQ_BU_ROOT: begin
        // a lone root separator stays
        if (mem_rdata != sep_char) begin
          wp_nxt = '0;
        end
      end
      pn_pkg::SQ_BU_CHECK: begin
        if (mem_rdata != sep_char) begin
          wp_nxt = wp_m1;
        end
      end
      pn_pkg::SQ_FIN: begin
        if (wp_r == '0) begin
          put_dots_nxt = 2'd0;
          put_last_nxt = sep_char;
        end
      end
      pn_pkg::SQ_FIN_CHECK: begin
        if (mem_rdata == sep_char) begin
          wp_nxt = wp_m1;
        end
      end
      pn_pkg::SQ_RD_CHECK: begin
        res_byte_nxt = read_in_range ? mem_rdata : pn_pkg::NUL_CHAR;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pn_pkg::SQ_IDLE;
      pstate_r    <= pn_pkg::PS_INIT;
      wp_r        <= '0;
      flen_r      <= '0;
      req_r       <= 1'b0;
      ovf_r       <= 1'b0;
      todo_join_r <= 1'b0;
      todo_char_r <= 1'b0;
      todo_fin_r  <= 1'b0;
      todo_end_r  <= 1'b0;
      put_dots_r  <= 2'd0;
    end else begin
      state_r     <= state_nxt;
      pstate_r    <= pstate_nxt;
      wp_r        <= wp_nxt;
      flen_r      <= flen_nxt;
      req_r       <= req_nxt;
      ovf_r       <= ovf_nxt;
      todo_join_r <= todo_join_nxt;
      todo_char_r <= todo_char_nxt;
      todo_fin_r  <= todo_fin_nxt;
      todo_end_r  <= todo_end_nxt;
      put_dots_r  <= put_dots_nxt;
    end
  end

  always_ff @(posedge clk) begin
    c_r        <= c_nxt;
    ridx_r     <= ridx_nxt;
    put_last_r <= put_last_nxt;
    res_byte_r <= res_byte_nxt;
  end

  assign res_valid      = (state_r == pn_pkg::SQ_DONE);
  assign res.overflowed = ovf_r;
  assign res.read_byte  = res_byte_r;
  assign res.result_length = (CW'(flen_r) > CW'(pn_pkg::LEN_MAX)) ?
                             pn_pkg::LEN_W'(pn_pkg::LEN_MAX) : pn_pkg::LEN_W'(flen_r);

endmodule

// File: dv/tb_path_normalizer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_path_normalizer_unit: self-checking bench for the path normaliser
// Pushes directory and request bytes and read-back transfers through the
// valid/ready channels. A bench model of parser and store predicts each
// result but those of typed table rows; every result field is checked in
// order. A directed table comes first. Random paths follow under six
// separator and dot settings, with three idling patterns on both channels.
// ----------------------------------------------------------------------------
module tb_path_normalizer_unit;

  localparam int     STORE_DEPTH     = pn_pkg::LINE_DEPTH_DEF;
  localparam int     ITEMS_PER_PHASE = 250;
  localparam int     PHASES          = 6;
  localparam int     DRAIN_TAIL      = 1200;
  localparam longint CYCLE_LIMIT     = 2_000_000;

  typedef struct packed {
    logic               typed;
    pn_pkg::pn_item_t   item;
    pn_pkg::pn_result_t res;
  } dir_row_t;

  localparam int DIR_ROWS = 25;
  localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
    // reads straight after reset, then an empty path that becomes the root
    '{1'b1, '{pn_pkg::REQ_READ, 8'd0,             1'b0, 8'd0},  '{9'd0, 1'b0, 8'd0}},
    '{1'b1, '{pn_pkg::REQ_READ, 8'hff,            1'b1, 8'hff}, '{9'd0, 1'b0, 8'd0}},
    '{1'b1, '{pn_pkg::REQ_PUSH, pn_pkg::NUL_CHAR, 1'b0, 8'd0},  '{9'd1, 1'b0, 8'd0}},
    '{1'b1, '{pn_pkg::REQ_READ, 8'd0,             1'b0, 8'd0},  '{9'd1, 1'b0, "/"}},
    '{1'b1, '{pn_pkg::REQ_READ, 8'd0,             1'b0, 8'd1},  '{9'd1, 1'b0, 8'd0}},
    // parent at the root keeps the leading separator
    '{1'b0, '{pn_pkg::REQ_PUSH, "/",              1'b0, 8'd0},  '0},
    '{1'b0, '{pn_pkg::REQ_PUSH, ".",              1'b1, 8'd0},  '0},
    '{1'b0, '{pn_pkg::REQ_PUSH, ".",              1'b1, 8'd0},  '0},
    '{1'b0, '{pn_pkg::REQ_PUSH, "/",              1'b1, 8'd0},  '0},
    '{1'b0, '{pn_pkg::REQ_PUSH, 8'hff,            1'b1, 8'hff}, '0},
    '{1'b0, '{pn_pkg::REQ_PUSH, pn_pkg::NUL_CHAR, 1'b1, 8'd0},  '0},
    '{1'b0, '{pn_pkg::REQ_READ, 8'd0,             1'b0, 8'd1},  '0},
    // relative directory, late directory byte, trailing separator
    '{1'b0, '{pn_pkg::REQ_PUSH, "x",              1'b0, 8'd0},  '0},
    '{1'b0, '{pn_pkg::REQ_PUSH, ".",              1'b0, 8'd0},  '0},
    '{1'b0, '{pn_pkg::REQ_PUSH, "y",              1'b1, 8'd0},  '0},
    '{1'b0, '{pn_pkg::REQ_PUSH, "z",              1'b0, 8'd0},  '0},
    '{1'b0, '{pn_pkg::REQ_PUSH, "/",              1'b1, 8'd0},  '0},
    '{1'b0, '{pn_pkg::REQ_PUSH, 8'h01,            1'b1, 8'd0},  '0},
    '{1'b0, '{pn_pkg::REQ_PUSH, "/",              1'b1, 8'd0},  '0},
    '{1'b0, '{pn_pkg::REQ_PUSH, pn_pkg::NUL_CHAR, 1'b0, 8'd0},  '0},
    '{1'b0, '{pn_pkg::REQ_READ, 8'd0,             1'b0, 8'd0},  '0},
    // absolute request drops the directory
    '{1'b0, '{pn_pkg::REQ_PUSH, "q",              1'b0, 8'd0},  '0},
    '{1'b0, '{pn_pkg::REQ_PUSH, "/",              1'b1, 8'd0},  '0},
    '{1'b0, '{pn_pkg::REQ_PUSH, pn_pkg::NUL_CHAR, 1'b1, 8'd0},  '0},
    '{1'b0, '{pn_pkg::REQ_READ, 8'd0,             1'b0, 8'hff}, '0}
  };

  logic                         clk;
  logic                         rst_n;
  logic                         in_valid;
  logic                         in_ready;
  logic                         in_req_type;
  logic [7:0]                   in_path_byte;
  logic                         in_from_request;
  logic [7:0]                   in_read_index;
  logic                         out_valid;
  logic                         out_ready;
  logic [pn_pkg::LEN_W-1:0]     out_result_length;
  logic                         out_overflowed;
  logic [7:0]                   out_read_byte;
  logic                         cfg_we;
  logic [pn_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [7:0]                   cfg_data;

  path_normalizer_unit i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_req_type       (in_req_type),
    .in_path_byte      (in_path_byte),
    .in_from_request   (in_from_request),
    .in_read_index     (in_read_index),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_result_length (out_result_length),
    .out_overflowed    (out_overflowed),
    .out_read_byte     (out_read_byte),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  // normaliser state as the bench sees it
  logic [7:0]           sep_q;
  logic [7:0]           dot_q;
  pn_pkg::parse_state_t pstate;
  logic [7:0]           line_mem [STORE_DEPTH];
  int unsigned          wr_pos;
  int unsigned          path_len;
  bit                   req_seen;
  bit                   ovf_q;

  pn_pkg::pn_result_t expected_results [$];
  pn_pkg::pn_result_t head_result;
  int                 n_fail;
  int                 items_sent;
  int                 in_idle_pct;
  int                 out_idle_pct;
  bit                 scramble_source;
  longint unsigned    cycle_count = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("path_normalizer_unit: mismatch");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= out_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $error("result transfer with nothing expected: length %0d", out_result_length);
        n_fail++;
      end else begin
        head_result = expected_results.pop_front();
        if (out_result_length !== head_result.result_length) begin
          $error("result_length: expected %0d, got %0d",
                 head_result.result_length, out_result_length);
          n_fail++;
        end
        if (out_overflowed !== head_result.overflowed) begin
          $error("overflowed: expected %0d, got %0d",
                 head_result.overflowed, out_overflowed);
          n_fail++;
        end
        if (out_read_byte !== head_result.read_byte) begin
          $error("read_byte: expected %0d, got %0d",
                 head_result.read_byte, out_read_byte);
          n_fail++;
        end
      end
    end
  end

  function automatic void store_char(logic [7:0] c);
    if (wr_pos < STORE_DEPTH) begin
      line_mem[wr_pos] = c;
      wr_pos++;
    end else begin
      ovf_q = 1'b1;
    end
  endfunction

  // parent component: drop the last stored component, never the root
  function automatic void walk_back_component();
    if (wr_pos > 0 && !(wr_pos == 1 && line_mem[0] == sep_q)) wr_pos--;
    while (wr_pos > 0 && line_mem[wr_pos-1] != sep_q) wr_pos--;
  endfunction

  function automatic void feed_char(logic [7:0] c);
    bit is_sep;
    bit is_dot;
    is_sep = (sep_q != 8'd0) && (c == sep_q);
    is_dot = (dot_q != 8'd0) && (c == dot_q);
    case (pstate)
      pn_pkg::PS_SEP: begin
        if (is_dot && !is_sep) begin
          pstate = pn_pkg::PS_DOT;
        end else if (!is_sep) begin
          store_char(c);
          pstate = pn_pkg::PS_FIELD;
        end
      end
      pn_pkg::PS_FIELD: begin
        if (is_sep) begin
          store_char(sep_q);
          pstate = pn_pkg::PS_SEP;
        end else begin
          store_char(c);
        end
      end
      pn_pkg::PS_DOT: begin
        if (is_dot) begin
          pstate = pn_pkg::PS_DOTDOT;
        end else if (is_sep) begin
          pstate = pn_pkg::PS_SEP;
        end else begin
          store_char(dot_q);
          store_char(c);
          pstate = pn_pkg::PS_FIELD;
        end
      end
      pn_pkg::PS_DOTDOT: begin
        if (is_sep) begin
          walk_back_component();
          pstate = pn_pkg::PS_SEP;
        end else begin
          store_char(dot_q);
          store_char(dot_q);
          store_char(c);
          pstate = pn_pkg::PS_FIELD;
        end
      end
      default: begin
        if (is_sep) begin
          store_char(sep_q);
          pstate = pn_pkg::PS_SEP;
        end else if (is_dot) begin
          pstate = pn_pkg::PS_DOT;
        end else begin
          store_char(c);
          pstate = pn_pkg::PS_FIELD;
        end
      end
    endcase
  endfunction

  // updates the state for one accepted transfer; returns 1 if it gives a result
  function automatic bit normalise(input pn_pkg::pn_item_t it,
                                   output pn_pkg::pn_result_t r);
    r = '0;
    if (it.req_type == pn_pkg::REQ_READ) begin
      r.result_length = pn_pkg::LEN_W'((path_len > pn_pkg::LEN_MAX) ?
                                       pn_pkg::LEN_MAX : path_len);
      r.overflowed    = ovf_q;
      r.read_byte     = (it.read_index < path_len) ? line_mem[it.read_index] : 8'd0;
      return 1'b1;
    end
    if (pstate == pn_pkg::PS_INIT && !req_seen && wr_pos == 0) ovf_q = 1'b0;
    if (!req_seen && (it.from_request || it.path_byte == pn_pkg::NUL_CHAR)) begin
      req_seen = 1'b1;
      if (it.path_byte != pn_pkg::NUL_CHAR && sep_q != 8'd0 && it.path_byte == sep_q) begin
        pstate = pn_pkg::PS_INIT;
        wr_pos = 0;
        ovf_q  = 1'b0;
      end else begin
        feed_char((sep_q != 8'd0) ? sep_q : pn_pkg::JOIN_SEP_DEFAULT);
      end
    end
    if (it.path_byte != pn_pkg::NUL_CHAR) begin
      feed_char(it.path_byte);
      return 1'b0;
    end
    // end of path: pending parent, empty result, trailing separator
    if (pstate == pn_pkg::PS_DOTDOT) walk_back_component();
    if (wr_pos == 0) begin
      store_char(sep_q);
    end else if (wr_pos > 1 && line_mem[wr_pos-1] == sep_q) begin
      wr_pos--;
    end
    path_len = wr_pos;
    pstate   = pn_pkg::PS_INIT;
    wr_pos   = 0;
    req_seen = 1'b0;
    r.result_length = pn_pkg::LEN_W'((path_len > pn_pkg::LEN_MAX) ?
                                     pn_pkg::LEN_MAX : path_len);
    r.overflowed    = ovf_q;
    return 1'b1;
  endfunction

  task automatic push_transfer(pn_pkg::pn_item_t it, bit typed,
                               pn_pkg::pn_result_t typed_res);
    pn_pkg::pn_result_t r;
    @(negedge clk);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_req_type     <= it.req_type;
    in_path_byte    <= it.path_byte;
    in_from_request <= it.from_request;
    in_read_index   <= it.read_index;
    do @(posedge clk); while (!in_ready);
    if (normalise(it, r)) expected_results.push_back(typed ? typed_res : r);
    items_sent++;
  endtask

  task automatic drain(int tail);
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (tail) @(posedge clk);
  endtask

  task automatic write_reg(logic [pn_pkg::CFG_IDX_W-1:0] idx, logic [7:0] v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == pn_pkg::CFG_SEPARATOR) sep_q = v;
    else                              dot_q = v;
  endtask

  task automatic read_back();
    pn_pkg::pn_item_t it;
    it.req_type     = pn_pkg::REQ_READ;
    it.path_byte    = 8'($urandom_range(0, 255));
    it.from_request = 1'($urandom_range(0, 1));
    if (path_len > 0 && $urandom_range(0, 99) < 80)
      it.read_index = 8'($urandom_range(0, path_len - 1));
    else
      it.read_index = 8'($urandom_range(0, 255));
    push_transfer(it, 1'b0, '0);
  endtask

  task automatic push_byte(logic [7:0] b, logic from);
    pn_pkg::pn_item_t it;
    if ($urandom_range(0, 99) < 10) read_back();
    it.req_type     = pn_pkg::REQ_PUSH;
    it.path_byte    = b;
    it.from_request = scramble_source ? 1'($urandom_range(0, 1)) : from;
    it.read_index   = 8'($urandom_range(0, 255));
    push_transfer(it, 1'b0, '0);
  endtask

  function automatic logic [7:0] name_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 8'h61 + 8'($urandom_range(0, 25));
    if (r < 85) return dot_q;
    return 8'($urandom_range(1, 255));
  endfunction

  task automatic push_separator(logic from);
    push_byte(sep_q, from);
    if ($urandom_range(0, 99) < 12) push_byte(sep_q, from);
  endtask

  task automatic push_component(logic from);
    int r;
    int n;
    r = $urandom_range(0, 99);
    if (r < 14) begin
      push_byte(dot_q, from);
    end else if (r < 28) begin
      push_byte(dot_q, from);
      push_byte(dot_q, from);
    end else if (r < 34) begin
      repeat (3) push_byte(dot_q, from);
    end else if (r < 40) begin
      push_byte(dot_q, from);
      push_byte(name_char(), from);
    end else begin
      n = $urandom_range(1, 6);
      repeat (n) push_byte(name_char(), from);
    end
  endtask

  // one path: directory, request, terminating nul, then a few reads
  task automatic push_path(bit long_path);
    int r;
    int n;
    scramble_source = ($urandom_range(0, 99) < 4);
    r = $urandom_range(0, 99);
    if (long_path) begin
      // far more than the store holds
      push_byte(sep_q, 1'b0);
      repeat (40) begin
        repeat (7) push_byte(8'h61 + 8'($urandom_range(0, 25)), 1'b0);
        push_byte(sep_q, 1'b0);
      end
    end else if (r >= 10) begin
      if (r < 75) push_separator(1'b0);
      n = $urandom_range(0, 4);
      for (int i = 0; i < n; i++) begin
        push_component(1'b0);
        if (i < n - 1 || $urandom_range(0, 99) < 20) push_separator(1'b0);
      end
    end
    r = $urandom_range(0, 99);
    if (r >= 10) begin
      if (r < 35) push_separator(1'b1);
      n = $urandom_range(0, 5);
      for (int i = 0; i < n; i++) begin
        push_component(1'b1);
        if (i < n - 1 || $urandom_range(0, 99) < 15) push_separator(1'b1);
      end
    end
    // a few paths run on into the next one with no nul
    if ($urandom_range(0, 99) >= 3) push_byte(pn_pkg::NUL_CHAR, 1'($urandom_range(0, 1)));
    n = $urandom_range(0, 2);
    repeat (n) read_back();
  endtask

  initial begin
    int phase_start;
    logic [7:0] v;
    in_valid        = 1'b0;
    in_req_type     = pn_pkg::REQ_PUSH;
    in_path_byte    = 8'd0;
    in_from_request = 1'b0;
    in_read_index   = 8'd0;
    out_ready       = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = pn_pkg::CFG_SEPARATOR;
    cfg_data        = 8'd0;
    rst_n           = 1'b0;
    n_fail          = 0;
    items_sent      = 0;
    in_idle_pct     = 13;
    out_idle_pct    = 52;
    sep_q           = pn_pkg::SEP_DEFAULT;
    dot_q           = pn_pkg::DOT_DEFAULT;
    pstate          = pn_pkg::PS_INIT;
    wr_pos          = 0;
    path_len        = 0;
    req_seen        = 1'b0;
    ovf_q           = 1'b0;
    scramble_source = 1'b0;
    for (int i = 0; i < STORE_DEPTH; i++) line_mem[i] = 8'd0;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < DIR_ROWS; i++)
      push_transfer(DIR_TABLE[i].item, DIR_TABLE[i].typed, DIR_TABLE[i].res);
    drain(DRAIN_TAIL);

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph < 2) begin
        in_idle_pct  = 13;
        out_idle_pct = 52;
      end else if (ph < 4) begin
        in_idle_pct  = 52;
        out_idle_pct = 13;
      end else begin
        in_idle_pct  = 0;
        out_idle_pct = 0;
      end
      case (ph)
        0: begin
          write_reg(pn_pkg::CFG_SEPARATOR, pn_pkg::SEP_DEFAULT);
          write_reg(pn_pkg::CFG_DOT, pn_pkg::DOT_DEFAULT);
        end
        1: begin
          write_reg(pn_pkg::CFG_SEPARATOR, 8'd1);
          write_reg(pn_pkg::CFG_DOT, 8'd255);
        end
        2: begin
          write_reg(pn_pkg::CFG_SEPARATOR, 8'd255);
          write_reg(pn_pkg::CFG_DOT, 8'd1);
        end
        3: begin
          write_reg(pn_pkg::CFG_SEPARATOR, 8'd92);
          write_reg(pn_pkg::CFG_DOT, pn_pkg::DOT_DEFAULT);
        end
        4: begin
          // separator and dot the same byte
          v = 8'($urandom_range(1, 255));
          write_reg(pn_pkg::CFG_SEPARATOR, v);
          write_reg(pn_pkg::CFG_DOT, v);
        end
        default: begin
          write_reg(pn_pkg::CFG_SEPARATOR, 8'($urandom_range(1, 255)));
          write_reg(pn_pkg::CFG_DOT, 8'($urandom_range(1, 255)));
        end
      endcase
      phase_start = items_sent;
      push_path(ph == 1);
      while (items_sent - phase_start < ITEMS_PER_PHASE) begin
        push_path($urandom_range(0, 24) == 0);
        // hold the sender until every result is back
        if ($urandom_range(0, 39) == 0) drain(0);
      end
      // finish a path left open by a missing nul
      if (req_seen || wr_pos != 0 || pstate != pn_pkg::PS_INIT)
        push_byte(pn_pkg::NUL_CHAR, 1'b1);
      drain(DRAIN_TAIL);
    end

    if (n_fail == 0) begin
      $display("path_normalizer_unit: match");
    end else begin
      $display("path_normalizer_unit: mismatch");
    end
    $finish;
  end

endmodule
